// ===== hw/rtl/stb_pkg.sv =====
package stb_pkg;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam int TIME_W      = 32;
    localparam int TAG_W       = 16;
    localparam int OUT_IDX_W   = 4;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_SCAN
    } t_state;

    // Operands for the shared time unit.
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_cmp_req;

endpackage

// ===== hw/rtl/stb_cmp.sv =====
module stb_cmp (
    input  stb_pkg::t_cmp_req              i_req,
    input  logic [stb_pkg::TIME_W-1:0]     i_now,
    input  logic [stb_pkg::TIME_W-1:0]     i_delay,
    output logic [stb_pkg::TIME_W-1:0]     o_due,
    output logic                           o_gt
);
    import stb_pkg::*;

    logic [TIME_W-1:0] sum;

    // Deadline arithmetic wraps modulo 2^32; a deadline sum of zero is replaced by one.
    assign sum   = i_now + i_delay;
    assign o_due = (sum == '0) ? TIME_W'(1) : sum;

    // Unsigned greater-than shared by start, wrap detection and the scan.
    assign o_gt = i_req.a > i_req.b;

endmodule

// ===== hw/rtl/soft_timer_bank_with_wrap.sv =====
// Bank of one-shot millisecond timers with wrap-aware expiry.
// Command channel: an item is taken at a clock edge with i_start high and
// o_busy low. kind selects tick, start or cancel; start and cancel address
// i_timer_index, start arms now plus delay, tick carries the current time.
// Start, cancel and unused kinds keep o_busy high through ST_OP after accept.
// A tick keeps o_busy high while ST_OP latches the wrap decision, then while
// ST_SCAN does one deadline memory read per timer, all through a single
// shared compare unit, and drains the read pipeline. Each expiry is one cycle
// on o_result_valid with o_expired_index, o_listener and o_last; o_last marks
// the final expiry of the tick. Expiries are held one step so that o_last is
// known, so the final one appears in the same cycle that o_busy falls. A tick
// reports at most 16 expiries. The receiver cannot stall; results are never
// held back. Configuration (o_cfg_ready is always high) sets the listener
// tag; the user must write it only while the bank is idle (not enforced).
// Reset idles all timers, clears the wrap flags, the previous time and tag.
module soft_timer_bank_with_wrap #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [1:0]                         i_kind,
    input  logic [7:0]                         i_timer_index,
    input  logic [stb_pkg::TIME_W-1:0]         i_delay_ms,
    input  logic [stb_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stb_pkg::TAG_W-1:0]          i_cfg_data,
    output logic                               o_result_valid,
    output logic [stb_pkg::OUT_IDX_W-1:0]      o_expired_index,
    output logic [stb_pkg::TAG_W-1:0]          o_listener,
    output logic                               o_last
);
    import stb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PTR_W = $clog2(NUM_TIMERS + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_TIMERS);
    localparam logic [8:0] NUM_T9 = 9'(NUM_TIMERS);

    t_state r_state, n_state;

    logic [1:0]         r_kind;
    logic [7:0]         r_idx;
    logic [TIME_W-1:0]  r_delay;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_prev_time;
    logic               r_wrapped;
    logic [TAG_W-1:0]   r_listener;

    logic [NUM_TIMERS-1:0] r_valid;
    logic [NUM_TIMERS-1:0] r_wrap;
    logic [TIME_W-1:0]     r_mem [NUM_TIMERS];
    logic [TIME_W-1:0]     r_rd_data;

    logic [PTR_W-1:0]     r_rd_ptr;
    logic                 r_ev_vld;
    logic [IDX_W-1:0]     r_ev_idx;
    logic [RES_CNT_W-1:0] r_count;

    logic                 r_pend_vld;
    logic [OUT_IDX_W-1:0] r_pend_idx;
    logic                 r_out_vld;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic                 r_out_last;

    logic accept;
    logic op_en;
    logic scan_en;
    logic in_range;
    logic scan_done;
    logic ev_armed;
    logic fire;
    logic clr_wrap;
    logic mem_we;

    t_cmp_req          cmp_req;
    logic [TIME_W-1:0] due;
    logic              gt;

    stb_cmp u_cmp (
        .i_req   (cmp_req),
        .i_now   (r_now),
        .i_delay (r_delay),
        .o_due   (due),
        .o_gt    (gt)
    );

    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;
    assign in_range    = {1'b0, r_idx} < NUM_T9;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_OP;
                end
            end
            ST_OP: begin
                n_state = (r_kind == KIND_TICK) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy  = 1'b1;
        op_en   = 1'b0;
        scan_en = 1'b0;
        unique case (r_state)
            ST_IDLE: o_busy  = 1'b0;
            ST_OP:   op_en   = 1'b1;
            ST_SCAN: scan_en = 1'b1;
            default: o_busy  = 1'b1;
        endcase
    end

    // Shared compare: start tests due > now, a tick first tests prev > now
    // (clock wrapped), then the scan tests now > deadline per timer.
    always_comb begin
        cmp_req.a = r_now;
        cmp_req.b = r_rd_data;
        if (op_en) begin
            if (r_kind == KIND_START) begin
                cmp_req.a = due;
                cmp_req.b = r_now;
            end else begin
                cmp_req.a = r_prev_time;
                cmp_req.b = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_idx   <= i_timer_index;
            r_delay <= i_delay_ms;
            r_now   <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listener <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_listener <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_wrapped   <= 1'b0;
        end else if (op_en && r_kind == KIND_TICK) begin
            r_prev_time <= r_now;
            r_wrapped   <= gt;
        end
    end

    // Deadline store; an entry is meaningful only while its valid bit is set.
    assign mem_we = op_en && r_kind == KIND_START && in_range;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx[IDX_W-1:0]] <= due;
        end
        r_rd_data <= r_mem[r_rd_ptr[IDX_W-1:0]];
    end

    // Scan pipeline: the address is issued, and evaluation follows in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_ev_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            r_ev_vld <= scan_en && (r_rd_ptr != PTR_END);
            if (op_en) begin
                r_rd_ptr <= '0;
                r_count  <= '0;
            end else if (scan_en) begin
                if (r_rd_ptr != PTR_END) begin
                    r_rd_ptr <= r_rd_ptr + PTR_W'(1);
                end
                if (fire) begin
                    r_count <= r_count + RES_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx <= r_rd_ptr[IDX_W-1:0];
    end

    assign scan_done = scan_en && (r_rd_ptr == PTR_END) && !r_ev_vld;
    assign ev_armed  = scan_en && r_ev_vld && r_valid[r_ev_idx]
                       && (r_count < RES_CNT_W'(MAX_RESULTS));
    assign fire      = ev_armed && (r_wrapped ? (!r_wrap[r_ev_idx] || gt)
                                              : (!r_wrap[r_ev_idx] && gt));
    assign clr_wrap  = ev_armed && r_wrapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wrap  <= '0;
        end else if (op_en && in_range) begin
            if (r_kind == KIND_START) begin
                r_valid[r_idx[IDX_W-1:0]] <= 1'b1;
                r_wrap[r_idx[IDX_W-1:0]]  <= !gt;
            end else if (r_kind == KIND_CANCEL) begin
                r_valid[r_idx[IDX_W-1:0]] <= 1'b0;
                r_wrap[r_idx[IDX_W-1:0]]  <= 1'b0;
            end
        end else begin
            if (fire) begin
                r_valid[r_ev_idx] <= 1'b0;
            end
            if (fire || clr_wrap) begin
                r_wrap[r_ev_idx] <= 1'b0;
            end
        end
    end

    // Each expiry waits in the pending slot until the next one or the end of
    // the scan decides whether it is the last of the tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (op_en) begin
                r_out_vld  <= 1'b0;
                r_pend_vld <= 1'b0;
            end else if (fire) begin
                r_out_vld  <= r_pend_vld;
                r_pend_vld <= 1'b1;
            end else if (scan_done && r_pend_vld) begin
                r_out_vld  <= 1'b1;
                r_pend_vld <= 1'b0;
            end else begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_idx  <= r_pend_idx;
            r_out_last <= 1'b0;
            r_pend_idx <= OUT_IDX_W'(r_ev_idx);
        end else if (scan_done) begin
            r_out_idx  <= r_pend_idx;
            r_out_last <= 1'b1;
        end
    end

    assign o_result_valid  = r_out_vld;
    assign o_expired_index = r_out_idx;
    assign o_listener      = r_listener;
    assign o_last          = r_out_last;

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == ST_SCAN)
        else $error("result strobe outside a tick scan");

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_W'(MAX_RESULTS))
        else $error("expiry count above cap");

    a_wrap_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_wrap & ~r_valid) == 0)
        else $error("wrap flag set on an idle timer");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last) |=> !o_result_valid)
        else $error("result after the last expiry of a tick");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

endmodule
